// ===== rtl/core/cbc_pkg.sv =====
// cbc_pkg: shared types, constants and register indices for the balance controller.
// No dependencies.
package cbc_pkg;

    // field widths
    localparam int ANGLE_W = 16;
    localparam int GYRO_W  = 16;
    localparam int MS_W    = 10;
    localparam int COUNT_W = 12;
    localparam int CMD_W   = 16;
    localparam int OFF_W   = 13;
    localparam int GAIN_W  = 16;
    localparam int TILT_W  = 13;
    localparam int SPEED_W = 20;
    localparam int DRIVE_W = 16;
    localparam int CFG_IDX_W = 3;

    // serial arithmetic widths
    localparam int OPA_W  = 22;
    localparam int ACC_W  = 40;
    localparam int DIVN_W = 27;
    localparam int STEP_W = 17;

    // fixed-point constants
    localparam logic [GAIN_W-1:0] FILT_KEEP = 16'd45875;
    localparam logic [GAIN_W-1:0] FILT_NEW  = 16'd19661;
    localparam int LEAN_LIMIT = 7680;
    localparam int TILT_LIMIT = 3840;
    localparam int SLEW_DIV   = 1000;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SLEW   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LF_OLD, ST_LF_NEW, ST_LF_WB,
        ST_RF_OLD, ST_RF_NEW, ST_RF_WB,
        ST_SLEW_MUL, ST_SLEW_DIV, ST_SLEW_WB,
        ST_TILT_MUL, ST_TILT_WB,
        ST_DRV_P, ST_DRV_D, ST_DRV_WB,
        ST_OUT
    } t_state;

    // command to a serial unit
    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } t_unit_cmd;

    // status from a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== rtl/core/cbc_mac.sv =====
// cbc_mac: bit-serial multiply-accumulate, one multiplier bit per cycle.
// Depends on cbc_pkg.
module cbc_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cbc_pkg::t_unit_cmd                    i_cmd,
    input  logic signed [cbc_pkg::OPA_W-1:0]      i_a,
    input  logic [cbc_pkg::GAIN_W-1:0]            i_b,
    output cbc_pkg::t_unit_sts                    o_sts,
    output logic signed [cbc_pkg::ACC_W-1:0]      o_acc
);
    import cbc_pkg::*;

    logic signed [ACC_W-1:0] r_acc, r_a;
    logic [GAIN_W-1:0]       r_b;
    logic [3:0]              r_cnt;
    logic                    r_busy, r_done, r_sub;

    // control: step through every multiplier bit, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift multiplicand up, multiplier down, add or subtract on a set bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            r_a   <= {{(ACC_W-OPA_W){i_a[OPA_W-1]}}, i_a};
            r_b   <= i_b;
            r_sub <= i_cmd.sub;
            if (i_cmd.clear) r_acc <= '0;
        end else if (r_busy) begin
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
            if (r_b[0]) r_acc <= r_sub ? (r_acc - r_a) : (r_acc + r_a);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("mac done without run");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == 4'd0) else $error("mac count not wrapped");
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("mac double done");
endmodule

// ===== rtl/core/cbc_div.sv =====
// cbc_div: restoring division by the constant slew divisor, one quotient bit per cycle.
// Depends on cbc_pkg.
module cbc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [cbc_pkg::DIVN_W-1:0]       i_num,
    output cbc_pkg::t_unit_sts               o_sts,
    output logic [cbc_pkg::STEP_W-1:0]       o_quot
);
    import cbc_pkg::*;

    localparam int REM_W = 11;
    localparam logic [REM_W-1:0] DIVISOR = REM_W'(SLEW_DIV);

    logic [DIVN_W-1:0] r_num, r_q;
    logic [REM_W-1:0]  r_rem;
    logic [4:0]        r_cnt;
    logic              r_busy, r_done;
    logic [REM_W-1:0]  rem_sh;

    assign rem_sh = {r_rem[REM_W-2:0], r_num[DIVN_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIVN_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one compare-subtract step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (rem_sh >= DIVISOR) begin
                r_rem <= rem_sh - DIVISOR;
                r_q   <= {r_q[DIVN_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[DIVN_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q[STEP_W-1:0];

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < DIVISOR) else $error("remainder out of range");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider double done");
endmodule

// ===== rtl/core/cascaded_balance_control.sv =====
// cascaded_balance_control: PD tilt loop with outer speed P loop, on serial arithmetic.
// Path to result valid: straight to the output state when fallen, two MAC passes without
// tick, eight MAC passes plus a serial divide with an outer tick.
// One step in flight: the next is accepted the cycle after the result loads; a stalled
// result holds the block. Reset (synchronous, active low) clears configuration, state,
// output valid, filtered speeds and targets. Depends on cbc_pkg, cbc_mac, cbc_div.
module cascaded_balance_control (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cbc_pkg::GAIN_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [cbc_pkg::ANGLE_W-1:0]     i_raw_angle,
    input  logic signed [cbc_pkg::GYRO_W-1:0]      i_gyro_rate,
    input  logic                                   i_outer_tick,
    input  logic [cbc_pkg::MS_W-1:0]               i_elapsed_ms,
    input  logic signed [cbc_pkg::COUNT_W-1:0]     i_left_count,
    input  logic signed [cbc_pkg::COUNT_W-1:0]     i_right_count,
    input  logic signed [cbc_pkg::CMD_W-1:0]       i_speed_command,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cbc_pkg::DRIVE_W-1:0]     o_balance_drive,
    output logic                                   o_fallen,
    output logic signed [cbc_pkg::TILT_W-1:0]      o_target_tilt,
    output logic signed [cbc_pkg::SPEED_W-1:0]     o_left_speed,
    output logic signed [cbc_pkg::SPEED_W-1:0]     o_right_speed
);
    import cbc_pkg::*;

    // configuration
    logic signed [OFF_W-1:0] r_angle_offset;
    logic [GAIN_W-1:0] r_angle_gain, r_rate_gain, r_speed_gain, r_speed_slew;

    // state and latched input transaction
    t_state r_state, n_state;
    logic signed [SPEED_W-1:0] r_lf, r_rf;
    logic signed [CMD_W-1:0]   r_ss;
    logic signed [TILT_W-1:0]  r_tt;
    logic signed [ANGLE_W-1:0] r_raw;
    logic signed [GYRO_W-1:0]  r_gyro;
    logic                      r_tick, r_fallen, r_issued;
    logic [MS_W-1:0]           r_ms;
    logic signed [COUNT_W-1:0] r_lc, r_rc;
    logic signed [CMD_W-1:0]   r_cmd;
    logic signed [DRIVE_W-1:0] r_drive;

    // output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_o_drive;
    logic                      r_o_fallen;
    logic signed [TILT_W-1:0]  r_o_tilt;
    logic signed [SPEED_W-1:0] r_o_lspeed, r_o_rspeed;

    // serial units
    t_unit_cmd mac_cmd;
    t_unit_sts mac_sts, div_sts;
    logic signed [OPA_W-1:0] mac_a;
    logic [GAIN_W-1:0]       mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    div_start;
    logic [STEP_W-1:0]       div_q;
    logic                    in_acc, in_fallen, load_out;

    cbc_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(mac_cmd),
        .i_a(mac_a), .i_b(mac_b), .o_sts(mac_sts), .o_acc(mac_acc)
    );

    cbc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(mac_acc[DIVN_W-1:0] + DIVN_W'(500)), .o_sts(div_sts), .o_quot(div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_fallen   = (i_raw_angle > ANGLE_W'(LEAN_LIMIT))
                      || (i_raw_angle < -ANGLE_W'(LEAN_LIMIT));
    assign load_out    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset <= '0;
            r_angle_gain   <= '0;
            r_rate_gain    <= '0;
            r_speed_gain   <= '0;
            r_speed_slew   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ANGLE_OFFSET: r_angle_offset <= i_cfg_data[OFF_W-1:0];
                REG_ANGLE_GAIN:   r_angle_gain   <= i_cfg_data;
                REG_RATE_GAIN:    r_rate_gain    <= i_cfg_data;
                REG_SPEED_GAIN:   r_speed_gain   <= i_cfg_data;
                REG_SPEED_SLEW:   r_speed_slew   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: next state and unit commands
    always_comb begin
        n_state       = r_state;
        mac_cmd       = '0;
        mac_a         = '0;
        mac_b         = '0;
        div_start     = 1'b0;
        case (r_state)
            ST_IDLE: if (in_acc) begin
                n_state = in_fallen ? ST_OUT : (i_outer_tick ? ST_LF_OLD : ST_DRV_P);
            end
            ST_LF_OLD, ST_RF_OLD: begin
                mac_cmd = '{start: !r_issued, clear: 1'b1, sub: 1'b0};
                mac_a   = (r_state == ST_LF_OLD) ? OPA_W'(r_lf) : OPA_W'(r_rf);
                mac_b   = FILT_KEEP;
                if (mac_sts.done) n_state = (r_state == ST_LF_OLD) ? ST_LF_NEW : ST_RF_NEW;
            end
            ST_LF_NEW, ST_RF_NEW: begin
                mac_cmd = '{start: !r_issued, clear: 1'b0, sub: 1'b0};
                mac_a   = (r_state == ST_LF_NEW) ? {{(OPA_W-COUNT_W-8){r_lc[COUNT_W-1]}}, r_lc, 8'b0}
                                                 : {{(OPA_W-COUNT_W-8){r_rc[COUNT_W-1]}}, r_rc, 8'b0};
                mac_b   = FILT_NEW;
                if (mac_sts.done) n_state = (r_state == ST_LF_NEW) ? ST_LF_WB : ST_RF_WB;
            end
            ST_LF_WB: n_state = ST_RF_OLD;
            ST_RF_WB: n_state = ST_SLEW_MUL;
            ST_SLEW_MUL: begin
                mac_cmd = '{start: !r_issued, clear: 1'b1, sub: 1'b0};
                mac_a   = OPA_W'(r_ms);
                mac_b   = r_speed_slew;
                if (mac_sts.done) n_state = ST_SLEW_DIV;
            end
            ST_SLEW_DIV: begin
                div_start = !r_issued;
                if (div_sts.done) n_state = ST_SLEW_WB;
            end
            ST_SLEW_WB: n_state = ST_TILT_MUL;
            ST_TILT_MUL: begin
                mac_cmd = '{start: !r_issued, clear: 1'b1, sub: 1'b0};
                mac_a   = {{(OPA_W-CMD_W-1){r_ss[CMD_W-1]}}, r_ss, 1'b0}
                        - OPA_W'(r_lf) - OPA_W'(r_rf);
                mac_b   = r_speed_gain;
                if (mac_sts.done) n_state = ST_TILT_WB;
            end
            ST_TILT_WB: n_state = ST_DRV_P;
            ST_DRV_P: begin
                mac_cmd = '{start: !r_issued, clear: 1'b1, sub: 1'b0};
                mac_a   = OPA_W'(r_tt) - OPA_W'(r_raw) + OPA_W'(r_angle_offset);
                mac_b   = r_angle_gain;
                if (mac_sts.done) n_state = ST_DRV_D;
            end
            ST_DRV_D: begin
                mac_cmd = '{start: !r_issued, clear: 1'b0, sub: 1'b1};
                mac_a   = {{(OPA_W-GYRO_W-3){r_gyro[GYRO_W-1]}}, r_gyro, 3'b0};
                mac_b   = r_rate_gain;
                if (mac_sts.done) n_state = ST_DRV_WB;
            end
            ST_DRV_WB: n_state = ST_OUT;
            ST_OUT: if (load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // post-processing of the accumulator and divider quotient
    logic signed [ACC_W-1:0] filt_q, tilt_q, drv_q, acc_rnd;
    logic signed [STEP_W:0]  slew_diff, slew_step, slew_err;

    always_comb begin
        filt_q    = (mac_acc + ACC_W'(32768)) >>> 16;
        tilt_q    = (ACC_W'(512) - mac_acc) >>> 10;
        acc_rnd   = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
        drv_q     = acc_rnd >>> 15;
        slew_diff = (STEP_W+1)'(r_cmd) - (STEP_W+1)'(r_ss);
        slew_step = {1'b0, div_q};
        if (slew_diff > slew_step)       slew_err = slew_step;
        else if (slew_diff < -slew_step) slew_err = -slew_step;
        else                             slew_err = slew_diff;
    end

    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(524287))       return SPEED_W'(524287);
        else if (v < -ACC_W'(524288)) return SPEED_W'(-524288);
        else                          return v[SPEED_W-1:0];
    endfunction

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_lf     <= '0;
            r_rf     <= '0;
            r_ss     <= '0;
            r_tt     <= '0;
            r_fallen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_issued <= 1'b0;
            else if (mac_cmd.start || div_start) r_issued <= 1'b1;
            if (in_acc) begin
                r_fallen <= in_fallen;
                if (in_fallen) begin
                    r_lf <= '0;
                    r_rf <= '0;
                    r_ss <= '0;
                    r_tt <= '0;
                end
            end
            case (r_state)
                ST_LF_WB:   r_lf <= sat_speed(filt_q);
                ST_RF_WB:   r_rf <= sat_speed(filt_q);
                ST_SLEW_WB: r_ss <= r_ss + r_cmd - r_cmd + CMD_W'(slew_err);
                ST_TILT_WB: begin
                    if (tilt_q > ACC_W'(TILT_LIMIT))       r_tt <= TILT_W'(TILT_LIMIT);
                    else if (tilt_q < -ACC_W'(TILT_LIMIT)) r_tt <= -TILT_W'(TILT_LIMIT);
                    else                                   r_tt <= tilt_q[TILT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // transaction capture and drive result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw   <= i_raw_angle;
            r_gyro  <= i_gyro_rate;
            r_tick  <= i_outer_tick;
            r_ms    <= i_elapsed_ms;
            r_lc    <= i_left_count;
            r_rc    <= i_right_count;
            r_cmd   <= i_speed_command;
            r_drive <= '0;
        end else if (r_state == ST_DRV_WB) begin
            if (drv_q > ACC_W'(32767))       r_drive <= DRIVE_W'(32767);
            else if (drv_q < -ACC_W'(32768)) r_drive <= DRIVE_W'(-32768);
            else                             r_drive <= drv_q[DRIVE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_drive  <= r_fallen ? '0 : r_drive;
            r_o_fallen <= r_fallen;
            r_o_tilt   <= r_tt;
            r_o_lspeed <= r_lf;
            r_o_rspeed <= r_rf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_balance_drive = r_o_drive;
    assign o_fallen        = r_o_fallen;
    assign o_target_tilt   = r_o_tilt;
    assign o_left_speed    = r_o_lspeed;
    assign o_right_speed   = r_o_rspeed;

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !mac_sts.busy && !div_sts.busy) else $error("unit busy at accept");
    a_fallen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fallen |-> o_balance_drive == '0 && o_target_tilt == '0)
        else $error("fallen step drives");
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tt <= TILT_W'(TILT_LIMIT) && r_tt >= -TILT_W'(TILT_LIMIT))
        else $error("target tilt out of range");
    a_tick_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LF_OLD |-> r_tick && !r_fallen) else $error("speed loop without tick");
endmodule
